// ----- src/lcgss_pkg.sv -----
// Shared types and constants for the LCG seed chunk match search block.
// Used by the ring cells, the draw unit, the top level and the checker.
package lcgss_pkg;

  // Table depth; the ring has one cell per table slot.
  localparam int MaxEntries = 64;
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = $clog2(MaxEntries + 1);
  // Index compares are done at this width, wide enough for table depths below 2048.
  localparam int CmpW = 11;

  localparam int SeedW  = 48;
  localparam int HitW   = 7;
  localparam int CfgW   = 7;
  localparam int DrawW  = 31;
  localparam int DrawLo = 17;

  localparam logic [SeedW-1:0] SeedXor  = 48'h0005_E434_E432;
  localparam logic [23:0]      LcgMulLo = 24'hECE66D;
  localparam logic [10:0]      LcgMulHi = 11'h5DE;
  localparam logic [SeedW-1:0] LcgAdd   = 48'h0000_0000_000B;

  // Divisibility by five: multiply by the inverse of 5 mod 2^32 and compare.
  localparam logic [31:0] Inv5    = 32'hCCCC_CCCD;
  localparam logic [31:0] Div5Lim = 32'h3333_3333;

  localparam logic [HitW-1:0] HitMax = 7'h7F;

  // Configuration register indexes.
  localparam logic RegActive   = 1'b0;
  localparam logic RegRequired = 1'b1;

  // Item kinds.
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTest = 1'b1;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } draw_tag_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } draw_res_t;

endpackage

// ----- src/lcgss_cell.sv -----
// One ring cell: holds one 48-bit table offset and passes it to its neighbor.
// Depends on lcgss_pkg.
module lcgss_cell (
  input  logic                       clk_i,
  input  lcgss_pkg::cell_ctl_t       ctl_i,
  input  logic [lcgss_pkg::SeedW-1:0] load_data_i,
  input  logic [lcgss_pkg::SeedW-1:0] shift_data_i,
  output logic [lcgss_pkg::SeedW-1:0] offset_o
);
  import lcgss_pkg::*;

  logic [SeedW-1:0] offset_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      offset_q <= load_data_i;
    end else if (ctl_i.shift) begin
      offset_q <= shift_data_i;
    end
  end

  assign offset_o = offset_q;

endmodule

// ----- src/lcgss_draw.sv -----
// Five-stage draw unit: seed plus offset, XOR, one LCG step, divisible-by-ten test.
// Depends on lcgss_pkg.
module lcgss_draw (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcgss_pkg::draw_tag_t        tag_i,
  input  logic [lcgss_pkg::SeedW-1:0] seed_i,
  input  logic [lcgss_pkg::SeedW-1:0] offset_i,
  output lcgss_pkg::draw_res_t        res_o
);
  import lcgss_pkg::*;

  draw_tag_t        t0_q, t1_q, t2_q, t3_q;
  logic [SeedW-1:0] x0_q;
  logic [SeedW-1:0] pll_q;
  logic [23:0]      plh_q, phl_q;
  logic [DrawW-1:0] draw_q;
  logic [31:0]      m_q;
  logic             even_q;
  logic             hit_q;
  logic             res_valid_q, res_last_q;

  logic [SeedW-1:0] x0_d;
  logic [SeedW-1:0] pll_d;
  logic [23:0]      plh_d, phl_d;
  logic [23:0]      mid_sum;
  logic [SeedW-1:0] lcg_sum;
  logic [31:0]      m_d;

  assign x0_d = (seed_i + offset_i) ^ SeedXor;

  // Product mod 2^48 split in 24-bit halves; the high-by-high term drops out.
  assign pll_d = x0_q[23:0] * LcgMulLo;
  assign plh_d = x0_q[23:0] * LcgMulHi;
  assign phl_d = x0_q[47:24] * LcgMulLo;

  assign mid_sum = plh_q + phl_q;
  assign lcg_sum = pll_q + {mid_sum, 24'd0} + LcgAdd;

  assign m_d = {1'b0, draw_q} * Inv5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q        <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      t0_q        <= tag_i;
      t1_q        <= t0_q;
      t2_q        <= t1_q;
      t3_q        <= t2_q;
      res_valid_q <= t3_q.valid;
      res_last_q  <= t3_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q   <= x0_d;
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    draw_q <= lcg_sum[SeedW-1:DrawLo];
    m_q    <= m_d;
    even_q <= ~draw_q[0];
    hit_q  <= even_q && (m_q <= Div5Lim);
  end

  assign res_o.valid = res_valid_q;
  assign res_o.last  = res_last_q;
  assign res_o.hit   = hit_q;

endmodule

// ----- src/lcg_seed_chunk_match_search.sv -----
// Top level of the LCG seed chunk match search block.
// Depends on lcgss_pkg, lcgss_cell and lcgss_draw.
//
// A load item writes one table slot. A test item rotates the ring of 64 offset
// cells once past a shared five-stage draw unit, one slot per cycle, then drains
// the draw unit and posts the result; the time a test takes is independent of
// active_entries, and no item is taken while a test runs. The result sits in an
// output register, so loads and the next test are taken while it waits; a
// finished test holds until that register is free. Table slots never loaded
// since reset read as unknown values.
module lcg_seed_chunk_match_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [5:0]                  entry_index_i,
  input  logic [lcgss_pkg::SeedW-1:0] entry_offset_i,
  input  logic [lcgss_pkg::SeedW-1:0] candidate_seed_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lcgss_pkg::SeedW-1:0] tested_seed_o,
  output logic [lcgss_pkg::HitW-1:0]  hit_count_o,
  output logic                        is_match_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [lcgss_pkg::CfgW-1:0]  cfg_data_i
);
  import lcgss_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  step_q, step_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SeedW-1:0] seed_q, seed_d;
  logic [HitW-1:0]  acc_q, acc_d;
  logic [CfgW-1:0]  active_q, required_q;
  logic             out_valid_q;
  logic [SeedW-1:0] out_seed_q;
  logic [HitW-1:0]  out_hits_q;
  logic             out_match_q;

  logic [SeedW-1:0] ring [MaxEntries];
  cell_ctl_t        cell_ctl [MaxEntries];
  draw_tag_t        tag;
  draw_res_t        res;
  logic             accept;
  logic             last_step;
  logic             post;
  logic [CmpW-1:0]  active_sat;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign last_step  = (step_q == IdxW'(MaxEntries - 1));
  assign post       = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign active_sat = (CmpW'(active_q) > CmpW'(MaxEntries)) ? CmpW'(MaxEntries)
                                                           : CmpW'(active_q);

  for (genvar i = 0; i < MaxEntries; i++) begin : g_ring
    assign cell_ctl[i].load  = accept && (req_type_i == ReqLoad) &&
                               (CmpW'(entry_index_i) == CmpW'(i));
    assign cell_ctl[i].shift = (state_q == StIssue);

    lcgss_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl[i]),
      .load_data_i (entry_offset_i),
      .shift_data_i(ring[(i + 1) % MaxEntries]),
      .offset_o    (ring[i])
    );
  end

  assign tag.valid = (state_q == StIssue) && (CmpW'(step_q) < CmpW'(cnt_q));
  assign tag.last  = (state_q == StIssue) && last_step;

  lcgss_draw u_draw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .seed_i  (seed_q),
    .offset_i(ring[0]),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    seed_d  = seed_q;
    acc_d   = acc_q;
    if (res.valid && res.hit && (acc_q != HitMax)) begin
      acc_d = acc_q + HitW'(1);
    end
    case (state_q)
      StIdle: begin
        if (accept && (req_type_i == ReqTest)) begin
          state_d = StIssue;
          step_d  = '0;
          cnt_d   = CntW'(active_sat);
          seed_d  = candidate_seed_i;
          acc_d   = '0;
        end
      end
      StIssue: begin
        step_d = step_q + IdxW'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (res.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (post) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      acc_q       <= '0;
      active_q    <= CfgW'(1);
      required_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      acc_q   <= acc_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegActive:   active_q   <= cfg_data_i;
          RegRequired: required_q <= cfg_data_i;
          default:     active_q   <= active_q;
        endcase
      end
      if (post) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    seed_q <= seed_d;
    if (post) begin
      out_seed_q  <= seed_q;
      out_hits_q  <= acc_q;
      out_match_q <= (acc_q >= required_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tested_seed_o = out_seed_q;
  assign hit_count_o   = out_hits_q;
  assign is_match_o    = out_match_q;

endmodule

// ----- src/lcgss_checker.sv -----
// Port-level checker for the LCG seed chunk match search block, bound to the top.
// Depends on lcgss_pkg; shadows the configuration registers from the write port.
module lcgss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [lcgss_pkg::SeedW-1:0] tested_seed_o,
  input logic [lcgss_pkg::HitW-1:0]  hit_count_o,
  input logic                        is_match_o,
  input logic                        cfg_we_i,
  input logic                        cfg_index_i,
  input logic [lcgss_pkg::CfgW-1:0]  cfg_data_i
);
  import lcgss_pkg::*;

  logic [CfgW-1:0] active_q, required_q;
  logic [CmpW-1:0] active_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= CfgW'(1);
      required_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegActive) begin
        active_q <= cfg_data_i;
      end else begin
        required_q <= cfg_data_i;
      end
    end
  end

  assign active_sat = (CmpW'(active_q) > CmpW'(MaxEntries)) ? CmpW'(MaxEntries)
                                                           : CmpW'(active_q);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(tested_seed_o) && $stable(hit_count_o))
    else $error("stalled result changed");

  a_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_match_o == (hit_count_o >= required_q)))
    else $error("match flag disagrees with hit count");

  a_hit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CmpW'(hit_count_o) <= active_sat))
    else $error("hit count exceeds active entries");

endmodule

bind lcg_seed_chunk_match_search lcgss_checker u_lcgss_checker (.*);
